### sv/largest_prime_sieve_core_defines.svh
// assertion helpers shared by the sieve core
`ifndef LARGEST_PRIME_SIEVE_CORE_DEFINES_SVH
`define LARGEST_PRIME_SIEVE_CORE_DEFINES_SVH

// concurrent check on a given clock and active-low reset
`define LPS_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the core clock and reset
`define LPS_ASSERT(lbl, prop, msg) `LPS_ASSERT_CR(lbl, i_clk, i_rst_n, prop, msg)

`endif

### sv/lps_pkg.sv
`default_nettype none

package lps_pkg;

    // field and working widths
    localparam int QUERY_W   = 16;
    localparam int SQ_W      = 17;
    localparam int X_W       = 9;
    localparam int INC_W     = 11;
    localparam int IDX_MIN_W = 17;

    // divisor walk start values: x = 3, x*x = 9, step to next square 4x+4 = 16
    localparam int FIRST_DIV = 3;
    localparam int FIRST_SQ  = 9;
    localparam int FIRST_INC = 16;
    localparam int DIV_STEP  = 2;
    localparam int INC_STEP  = 8;

    // the only even prime
    localparam int SMALLEST_PRIME = 2;

    // second operand choice of the shared adder
    typedef enum logic [2:0] {
        B_ONE,
        B_NEG_ONE,
        B_NEG_THREE,
        B_THREE,
        B_VAR
    } t_b_sel;

endpackage

`default_nettype wire

### sv/largest_prime_sieve_core.sv
// largest prime not above a query value, odd-only sieve
//
// input channel: i_in_valid / o_in_ready with i_query_value (16 bit n).
// output channel: o_out_valid / i_out_ready with o_largest_prime; one item
// out for every item in, 0 for n below 2, 2 for n equal to 2.
// o_in_ready is high only while the sequencer is idle; one query at a time.
// a query runs in phases on one shared adder/comparator and a one-port
// bit memory: a fill pass writing ones over count = (n-1)/2 entries,
// capped at the memory depth, then for each odd x with x*x <= n a check,
// an index step, a strike of each odd multiple from x*x up (about count/x
// for each x, less the entries below x*x) and a step to the next divisor,
// then a downward scan, an address and a wait state per entry, until a
// survivor is found.
// the result sits in an output register; while the receiver stalls the
// next query may be accepted and run, and it waits at its end for the
// register to drain. synchronous active-low reset clears the sequencer
// and the output valid; the memory needs no reset since every query
// refills the part it reads.
`default_nettype none
`include "largest_prime_sieve_core_defines.svh"

module largest_prime_sieve_core
    import lps_pkg::*;
#(
    parameter int SIEVE_ENTRIES = 32767
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [QUERY_W-1:0] i_query_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [QUERY_W-1:0] o_largest_prime
);

    localparam int AW = (SIEVE_ENTRIES > 1) ? $clog2(SIEVE_ENTRIES) : 1;
    localparam int IW = (AW > IDX_MIN_W) ? AW : IDX_MIN_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CLEAR,
        S_CHECK,
        S_IDX,
        S_STRIKE,
        S_NEXT,
        S_SCAN_ADDR,
        S_SCAN_WAIT,
        S_FIN
    } t_state;

    t_state               r_state,     n_state;
    logic [QUERY_W-1:0]   r_n,         n_n;
    logic [IW-1:0]        r_count,     n_count;
    logic [IW-1:0]        r_idx,       n_idx;
    logic [X_W-1:0]       r_x,         n_x;
    logic [SQ_W-1:0]      r_sq,        n_sq;
    logic [INC_W-1:0]     r_inc,       n_inc;
    logic [QUERY_W-1:0]   r_res,       n_res;
    logic [QUERY_W-1:0]   r_out,       n_out;
    logic                 r_out_valid, n_out_valid;

    logic [IW-1:0]        w_a, w_b_var, w_c, w_sum, w_half;
    logic                 w_less;
    t_b_sel               w_b_sel;
    logic                 w_ram_we, w_ram_wdata, w_ram_rdata;
    logic [AW-1:0]        w_ram_addr;

    // shared adder and comparator
    lps_alu #(
        .W (IW)
    ) u_alu (
        .i_a     (w_a),
        .i_b_sel (w_b_sel),
        .i_b_var (w_b_var),
        .i_c     (w_c),
        .o_sum   (w_sum),
        .o_less  (w_less)
    );

    // odd-only sieve bitmap, entry i stands for 2i+3
    lps_ram #(
        .WIDTH (1),
        .DEPTH (SIEVE_ENTRIES),
        .AW    (AW)
    ) u_sieve (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // entries covered by this query, (n-1)/2 before the cap at the memory depth
    assign w_half = IW'((r_n - QUERY_W'(1)) >> 1);

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_count     = r_count;
        n_idx       = r_idx;
        n_x         = r_x;
        n_sq        = r_sq;
        n_inc       = r_inc;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        w_a         = r_idx;
        w_b_sel     = B_ONE;
        w_b_var     = IW'(r_x);
        w_c         = r_count;
        w_ram_we    = 1'b0;
        w_ram_wdata = 1'b1;
        w_ram_addr  = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n     = i_query_value;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_n < QUERY_W'(SMALLEST_PRIME)) begin
                    n_res   = '0;
                    n_state = S_FIN;
                end else if (r_n == QUERY_W'(SMALLEST_PRIME)) begin
                    n_res   = QUERY_W'(SMALLEST_PRIME);
                    n_state = S_FIN;
                end else begin
                    n_count = (w_half > IW'(SIEVE_ENTRIES)) ? IW'(SIEVE_ENTRIES) : w_half;
                    n_idx   = '0;
                    n_x     = X_W'(FIRST_DIV);
                    n_sq    = SQ_W'(FIRST_SQ);
                    n_inc   = INC_W'(FIRST_INC);
                    n_state = S_CLEAR;
                end
            end
            // fill pass: set every covered entry
            S_CLEAR: begin
                if (w_less) begin
                    w_ram_we    = 1'b1;
                    w_ram_wdata = 1'b1;
                    n_idx       = w_sum;
                end else begin
                    n_state = S_CHECK;
                end
            end
            // stop the divisor walk once x*x exceeds n
            S_CHECK: begin
                w_a = IW'(r_n);
                w_c = IW'(r_sq);
                if (w_less) begin
                    n_idx   = r_count;
                    n_state = S_SCAN_ADDR;
                end else begin
                    n_state = S_IDX;
                end
            end
            // entry of x*x
            S_IDX: begin
                w_a     = IW'(r_sq);
                w_b_sel = B_NEG_THREE;
                n_idx   = w_sum >> 1;
                n_state = S_STRIKE;
            end
            // clear odd multiples, step x entries at a time
            S_STRIKE: begin
                w_b_sel = B_VAR;
                if (w_less) begin
                    w_ram_we    = 1'b1;
                    w_ram_wdata = 1'b0;
                    n_idx       = w_sum;
                end else begin
                    n_state = S_NEXT;
                end
            end
            // next odd divisor, square kept by running sum
            S_NEXT: begin
                w_a     = IW'(r_sq);
                w_b_sel = B_VAR;
                w_b_var = IW'(r_inc);
                n_sq    = w_sum[SQ_W-1:0];
                n_x     = r_x + X_W'(DIV_STEP);
                n_inc   = r_inc + INC_W'(INC_STEP);
                n_state = S_CHECK;
            end
            // downward scan: issue read of the entry below
            S_SCAN_ADDR: begin
                w_b_sel    = B_NEG_ONE;
                w_c        = IW'(1);
                w_ram_addr = w_sum[AW-1:0];
                if (w_less) begin
                    n_res   = QUERY_W'(SMALLEST_PRIME);
                    n_state = S_FIN;
                end else begin
                    n_idx   = w_sum;
                    n_state = S_SCAN_WAIT;
                end
            end
            // survivor found gives 2i+3
            S_SCAN_WAIT: begin
                w_a     = r_idx << 1;
                w_b_sel = B_THREE;
                if (w_ram_rdata) begin
                    n_res   = w_sum[QUERY_W-1:0];
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN_ADDR;
                end
            end
            // hand the result over once the output register is free
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n     <= n_n;
        r_count <= n_count;
        r_idx   <= n_idx;
        r_x     <= n_x;
        r_sq    <= n_sq;
        r_inc   <= n_inc;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_largest_prime = r_out;

    // checks
    `LPS_ASSERT(a_accept_starts,
        (i_in_valid && o_in_ready) |=> (r_state == S_START),
        "accepted item did not start a query")
    `LPS_ASSERT(a_write_phase,
        w_ram_we |-> (r_state == S_CLEAR || r_state == S_STRIKE),
        "sieve written outside fill or strike")
    `LPS_ASSERT(a_write_in_range,
        w_ram_we |-> (r_idx < r_count),
        "sieve write beyond covered entries")
    `LPS_ASSERT(a_result_form,
        o_out_valid |-> (o_largest_prime[0] || o_largest_prime == QUERY_W'(0)
            || o_largest_prime == QUERY_W'(SMALLEST_PRIME)),
        "even result other than 0 or 2")

endmodule

`default_nettype wire

### sv/lps_ram.sv
`default_nettype none

module lps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32767,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, optional write plus registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/lps_alu.sv
`default_nettype none

module lps_alu
    import lps_pkg::*;
#(
    parameter int W = 17
) (
    input  wire logic   [W-1:0] i_a,
    input  wire t_b_sel         i_b_sel,
    input  wire logic   [W-1:0] i_b_var,
    input  wire logic   [W-1:0] i_c,
    output logic        [W-1:0] o_sum,
    output logic                o_less
);

    logic [W-1:0] w_b;

    // second operand select
    always_comb begin
        case (i_b_sel)
            B_ONE:       w_b = W'(1);
            B_NEG_ONE:   w_b = {W{1'b1}};
            B_NEG_THREE: w_b = ~W'(2);
            B_THREE:     w_b = W'(3);
            B_VAR:       w_b = i_b_var;
            default:     w_b = '0;
        endcase
    end

    // one adder and one magnitude compare
    assign o_sum  = i_a + w_b;
    assign o_less = (i_a < i_c);

endmodule

`default_nettype wire
